// ----- sv/stsc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and result codes for the square tile symmetry classifier
// no dependencies

package stsc_pkg;

    localparam int PIXEL_W = 8;
    localparam int CODE_W  = 3;
    localparam int CFG_W   = 5;
    localparam int N_XFORM = 8;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [N_XFORM-1:0] t_flags;

    localparam t_code CODE_ROT90    = 3'd0;
    localparam t_code CODE_ROT180   = 3'd1;
    localparam t_code CODE_ROT270   = 3'd2;
    localparam t_code CODE_MIRROR   = 3'd3;
    localparam t_code CODE_MIR_ROT  = 3'd4;
    localparam t_code CODE_IDENTITY = 3'd5;
    localparam t_code CODE_NONE     = 3'd6;

    // flag bit order: rot90, rot180, rot270, mirror, mirror+rot90,
    // mirror+rot180, mirror+rot270, identity
    function automatic t_code pick_code(input t_flags f);
        t_code code;
        if (f[0])             code = CODE_ROT90;
        else if (f[1])        code = CODE_ROT180;
        else if (f[2])        code = CODE_ROT270;
        else if (f[3])        code = CODE_MIRROR;
        else if (|f[6:4])     code = CODE_MIR_ROT;
        else if (f[7])        code = CODE_IDENTITY;
        else                  code = CODE_NONE;
        return code;
    endfunction

endpackage

// ----- sv/square_tile_symmetry_classifier.sv -----
`timescale 1ns / 1ps
// square tile symmetry classifier: top level
// depends on stsc_pkg
//
// usage:
//   slave stream (i_s_axis_*) carries one 8-bit pixel per transfer in raster
//   order: n*n origin pixels, then n*n target pixels. n comes from the
//   config register (i_cfg_we / i_cfg_wdata); zero reads as 1, values above
//   MAX_SIZE saturate. a config write restarts the block at the origin.
//   master stream (o_m_axis_*) carries one transform code per tile pair.
//   the code becomes valid after the last target pixel transfer: the transfer
//   edge loads the read stage, then the output register loads unless stalled.
//   throughput is one pixel per cycle while not stalled: each target pixel
//   reads the origin store at eight places at once from its four dual-read copies.
//   a code waiting on the master side does not block pixels until the last
//   target pixel of the next tile reaches the compare stage; from then on
//   the slave side stalls until the waiting code is taken.
//   reset returns to origin loading with n = 1; the origin store is not
//   cleared, target pixels only read entries written for the same tile.

module square_tile_symmetry_classifier
    import stsc_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config: grid_size[4:0]
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // tdata: pixel[7:0]
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,
    // tdata: transform_code[2:0], zero fill [7:3]
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata
);

    localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NBANK = N_XFORM / 2;
    localparam logic [AW-1:0] MAX_A = AW'(MAX_SIZE);

    typedef logic [CW-1:0] t_cnt;
    typedef logic [AW-1:0] t_addr;

    function automatic t_addr addr_of(input t_cnt r, input t_cnt c);
        return AW'(AW'(r) * MAX_A + AW'(c));
    endfunction

    // control state
    t_cnt   r_last, n_last;
    t_cnt   r_row;
    t_cnt   r_col;
    logic   r_phase;
    logic   r_s1_valid;
    logic   r_s1_last;
    t_pixel r_s1_pixel;
    t_flags r_flags;
    logic   r_out_valid;
    t_code  r_out_code;

    t_pixel rd_data [N_XFORM];
    t_addr  rd_addr [N_XFORM];

    logic   stall;
    logic   accept;
    logic   col_end;
    logic   row_end;
    t_cnt   rr;
    t_cnt   rc;
    t_addr  wr_addr;
    t_flags mismatch;
    t_flags n_flags;

    assign stall   = r_out_valid && !i_m_axis_tready && r_s1_valid && r_s1_last;
    assign o_s_axis_tready = !stall;
    assign accept  = i_s_axis_tvalid && !stall;
    assign col_end = (r_col == r_last);
    assign row_end = (r_row == r_last);
    assign rr      = t_cnt'(r_last - r_row);
    assign rc      = t_cnt'(r_last - r_col);
    assign wr_addr = addr_of(r_row, r_col);

    always_comb begin
        rd_addr[0] = addr_of(rc, r_row);
        rd_addr[1] = addr_of(rr, rc);
        rd_addr[2] = addr_of(r_col, rr);
        rd_addr[3] = addr_of(r_row, rc);
        rd_addr[4] = addr_of(rc, rr);
        rd_addr[5] = addr_of(rr, r_col);
        rd_addr[6] = addr_of(r_col, r_row);
        rd_addr[7] = addr_of(r_row, r_col);
    end

    // saturate grid size into last index
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_last = '0;
        end else if ({1'b0, i_cfg_wdata} > (CFG_W+1)'(MAX_SIZE)) begin
            n_last = t_cnt'(MAX_SIZE - 1);
        end else begin
            n_last = t_cnt'(i_cfg_wdata - 5'd1);
        end
    end

    // four copies of the origin store, two read ports each
    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        t_pixel r_mem [DEPTH];
        t_pixel r_rd_a;
        t_pixel r_rd_b;

        always_ff @(posedge i_clk) begin
            if (accept && !r_phase) begin
                r_mem[wr_addr] <= i_s_axis_tdata;
            end
            if (!stall) begin
                r_rd_a <= r_mem[rd_addr[2*b]];
                r_rd_b <= r_mem[rd_addr[2*b+1]];
            end
        end

        assign rd_data[2*b]   = r_rd_a;
        assign rd_data[2*b+1] = r_rd_b;
    end

    always_comb begin
        for (int k = 0; k < N_XFORM; k++) begin
            mismatch[k] = (rd_data[k] != r_s1_pixel);
        end
        n_flags = r_flags & ~mismatch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_flags     <= '1;
            r_out_valid <= 1'b0;
        end else begin
            // output register, load wins over the transfer that frees it
            if (!i_cfg_we && !stall && r_s1_valid && r_s1_last) begin
                r_out_valid <= 1'b1;
                r_out_code  <= pick_code(n_flags);
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_last     <= n_last;
                r_row      <= '0;
                r_col      <= '0;
                r_phase    <= 1'b0;
                r_s1_valid <= 1'b0;
                r_s1_last  <= 1'b0;
                r_flags    <= '1;
            end else begin
                if (!stall) begin
                    // compare stage
                    if (r_s1_valid) begin
                        if (r_s1_last) begin
                            r_flags <= '1;
                        end else begin
                            r_flags <= n_flags;
                        end
                    end

                    // read stage, target pixels only
                    r_s1_valid <= accept && r_phase;
                    r_s1_last  <= col_end && row_end;
                    r_s1_pixel <= i_s_axis_tdata;
                end

                // raster counters
                if (accept) begin
                    if (col_end) begin
                        r_col <= '0;
                        if (row_end) begin
                            r_row   <= '0;
                            r_phase <= !r_phase;
                        end else begin
                            r_row <= t_cnt'(r_row + 1'b1);
                        end
                    end else begin
                        r_col <= t_cnt'(r_col + 1'b1);
                    end
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(8 - CODE_W)'(0), r_out_code};

endmodule

// ----- bench/square_tile_symmetry_classifier_test.sv -----
`timescale 1ns / 1ps
// testbench for square_tile_symmetry_classifier: streams origin/target tile pairs
// and checks every transform code against a predictor kept in the bench
// depends on stsc_pkg and the square_tile_symmetry_classifier top level

module square_tile_symmetry_classifier_test
    import stsc_pkg::*;
();

    localparam int MAX_SIDE   = 16;
    localparam int STORE_SIZE = MAX_SIDE * MAX_SIDE;
    localparam int DRAIN_TAIL = 8;

    // candidate transforms, in the bit order of the match flags
    typedef enum int unsigned {
        XF_ROT90,
        XF_ROT180,
        XF_ROT270,
        XF_MIRROR,
        XF_MIR_ROT90,
        XF_MIR_ROT180,
        XF_MIR_ROT270,
        XF_IDENTITY
    } t_xform;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    class symmetry_predictor;
        t_pixel      origin [STORE_SIZE];
        t_flags      flags;
        int unsigned side;
        int unsigned row;
        int unsigned col;
        bit          in_target;
        t_code       pending_codes [$];
        int          errors;

        function new();
            side   = 1;
            errors = 0;
            restart();
        endfunction

        // origin address that target pixel (r,c) must equal under transform xf
        static function int unsigned source_addr(t_xform xf, int unsigned r,
                                                 int unsigned c, int unsigned n);
            int unsigned rr;
            int unsigned rc;
            int unsigned sr;
            int unsigned sc;
            rr = n - 1 - r;
            rc = n - 1 - c;
            case (xf)
                XF_ROT90: begin
                    sr = rc; sc = r;
                end
                XF_ROT180: begin
                    sr = rr; sc = rc;
                end
                XF_ROT270: begin
                    sr = c; sc = rr;
                end
                XF_MIRROR: begin
                    sr = r; sc = rc;
                end
                XF_MIR_ROT90: begin
                    sr = rc; sc = rr;
                end
                XF_MIR_ROT180: begin
                    sr = rr; sc = c;
                end
                XF_MIR_ROT270: begin
                    sr = c; sc = r;
                end
                default: begin
                    sr = r; sc = c;
                end
            endcase
            return sr * MAX_SIDE + sc;
        endfunction

        function void restart();
            flags     = '1;
            row       = 0;
            col       = 0;
            in_target = 1'b0;
        endfunction

        function void set_grid(logic [CFG_W-1:0] value);
            if (value == 0) begin
                side = 1;
            end else if (value > MAX_SIDE) begin
                side = MAX_SIDE;
            end else begin
                side = value;
            end
            restart();
        endfunction

        // move to the next raster position, true when the tile just ended
        function bit step_raster();
            if (col + 1 < side) begin
                col++;
                return 1'b0;
            end
            col = 0;
            if (row + 1 < side) begin
                row++;
                return 1'b0;
            end
            row = 0;
            return 1'b1;
        endfunction

        function t_code best_code(t_flags f);
            if (f[XF_ROT90]) return CODE_ROT90;
            if (f[XF_ROT180]) return CODE_ROT180;
            if (f[XF_ROT270]) return CODE_ROT270;
            if (f[XF_MIRROR]) return CODE_MIRROR;
            if (f[XF_MIR_ROT90] || f[XF_MIR_ROT180] || f[XF_MIR_ROT270]) return CODE_MIR_ROT;
            if (f[XF_IDENTITY]) return CODE_IDENTITY;
            return CODE_NONE;
        endfunction

        function void take_pixel(t_pixel px);
            if (!in_target) begin
                origin[row * MAX_SIDE + col] = px;
                if (step_raster()) begin
                    in_target = 1'b1;
                    flags     = '1;
                end
            end else begin
                for (int k = 0; k < N_XFORM; k++) begin
                    if (origin[source_addr(t_xform'(k), row, col, side)] != px) flags[k] = 1'b0;
                end
                if (step_raster()) begin
                    pending_codes.push_back(best_code(flags));
                    restart();
                end
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task check_code(logic [7:0] word);
            t_code want;
            if (pending_codes.size() == 0) begin
                report_mismatch($sformatf("code word %h with no tile pair pending", word));
                return;
            end
            want = pending_codes.pop_front();
            if (word[CODE_W-1:0] !== want) begin
                report_mismatch($sformatf("transform code %0d, want %0d",
                                          word[CODE_W-1:0], want));
            end
            if (word[7:CODE_W] !== '0) begin
                report_mismatch($sformatf("fill bits %b not zero", word[7:CODE_W]));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             pix_tvalid;
    logic             pix_tready;
    t_pixel           pix_tdata;
    logic             code_tvalid;
    logic             code_tready;
    logic [7:0]       code_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int long_hold      = 0;

    logic [CFG_W-1:0] grid_plan [8] = '{5'd3, 5'd31, 5'd2, 5'd1, 5'd4, 5'd16, 5'd5, 5'd0};

    symmetry_predictor sym;

    always #2 i_clk = ~i_clk;

    square_tile_symmetry_classifier #(
        .MAX_SIZE(MAX_SIDE)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(pix_tvalid),
        .o_s_axis_tready(pix_tready),
        .i_s_axis_tdata (pix_tdata),
        .o_m_axis_tvalid(code_tvalid),
        .i_m_axis_tready(code_tready),
        .o_m_axis_tdata (code_tdata)
    );

    // code receiver: random stalls plus an optional long hold-off
    initial begin
        code_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && code_tvalid && code_tready) sym.check_code(code_tdata);
            if (long_hold > 0) begin
                code_tready <= 1'b0;
                long_hold--;
            end else begin
                code_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct = 88; recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0; recv_stall_pct = 88;
            end
            IDLE_BOTH: begin
                send_idle_pct = 26; recv_stall_pct = 26;
            end
            default: begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
        endcase
    endtask

    // offer one pixel, return in the step right after its transfer
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pix_tvalid <= 1'b1;
        pix_tdata  <= px;
        @(posedge i_clk);
        while (!pix_tready) @(posedge i_clk);
        sym.take_pixel(px);
    endtask

    task automatic drain_results();
        pix_tvalid <= 1'b0;
        while (sym.pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        sym.set_grid(value);
        cfg_we <= 1'b0;
    endtask

    // origin tile, then a transformed copy, sometimes damaged or replaced
    task automatic send_tile(input int unsigned n);
        t_pixel      org [STORE_SIZE];
        t_pixel      tgt [STORE_SIZE];
        t_pixel      pal_a;
        t_pixel      pal_b;
        int unsigned style;
        t_xform      xf;
        int unsigned a;
        style = $urandom_range(4);
        pal_a = t_pixel'($urandom);
        pal_b = t_pixel'($urandom);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                a = r * MAX_SIDE + c;
                if (style <= 1) org[a] = t_pixel'($urandom);
                else if (style <= 3) org[a] = $urandom_range(1) ? pal_a : pal_b;
                else org[a] = pal_a;
            end
        end
        xf = t_xform'($urandom_range(N_XFORM - 1));
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                tgt[r * MAX_SIDE + c] = org[symmetry_predictor::source_addr(xf, r, c, n)];
            end
        end
        case ($urandom_range(9))
            0, 1: begin
                a = $urandom_range(n - 1) * MAX_SIDE + $urandom_range(n - 1);
                tgt[a] ^= t_pixel'($urandom_range(255, 1));
            end
            2: begin
                foreach (tgt[i]) tgt[i] = t_pixel'($urandom);
            end
            default: ;
        endcase
        for (int i = 0; i < n * n; i++) send_pixel(org[(i / n) * MAX_SIDE + i % n]);
        for (int i = 0; i < n * n; i++) send_pixel(tgt[(i / n) * MAX_SIDE + i % n]);
    endtask

    // a tile pair cut short, left for the next grid write to abandon
    task automatic send_partial(input int unsigned n);
        int unsigned cap;
        cap = (2 * n * n - 1 < 40) ? 2 * n * n - 1 : 40;
        repeat ($urandom_range(cap, 1)) send_pixel(t_pixel'($urandom));
    endtask

    initial begin
        int unsigned tiles;
        sym = new();
        i_rst_n    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        pix_tvalid <= 1'b0;
        pix_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-pixel tiles after reset: unequal pixels match nothing, equal match all
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        drain_results();
        // zero grid size behaves as one
        write_grid(5'd0);
        send_pixel(8'hA5);
        send_pixel(8'hA5);
        drain_results();
        // asymmetric 2x2 tile against itself: identity only
        write_grid(5'd2);
        repeat (2) begin
            send_pixel(8'h00);
            send_pixel(8'hFF);
            send_pixel(8'h01);
            send_pixel(8'hFE);
        end
        // writes in the middle of a tile restart at the origin
        repeat (3) send_pixel(8'h5A);
        drain_results();
        write_grid(5'd31);
        repeat (5) send_pixel(8'h3C);
        drain_results();
        write_grid(5'd17);

        for (int p = 0; p < 8; p++) begin
            set_idling(t_idle_mode'(p % 4));
            write_grid(grid_plan[p]);
            tiles = 160 / (2 * sym.side * sym.side);
            if (tiles == 0) tiles = 1;
            // receiver holds off long enough for the block to back up
            if (p == 3) long_hold = 400;
            for (int t = 0; t < tiles; t++) begin
                if (p == 2 && t == tiles / 2) drain_results();
                send_tile(sym.side);
            end
            send_partial(sym.side);
            drain_results();
        end

        if (sym.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/stsc_pkg.sv
sv/square_tile_symmetry_classifier.sv
bench/square_tile_symmetry_classifier_test.sv
